// ----- rtl/dsha_pkg.sv -----
// Package with the SHA-256 constants, types and round functions of the double hasher.
package dsha_pkg;

    typedef logic [31:0] t_word;
    typedef t_word [7:0] t_state;
    typedef t_word [15:0] t_window;

    localparam int unsigned NumRounds = 64;
    localparam int unsigned NumRegs   = 6;

    typedef enum logic [2:0] {
        REG_MID_01  = 3'd0,
        REG_MID_23  = 3'd1,
        REG_MID_45  = 3'd2,
        REG_MID_67  = 3'd3,
        REG_TAIL_01 = 3'd4,
        REG_TAIL_2  = 3'd5
    } t_reg_idx;

    localparam t_word [63:0] RoundK = '{
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    localparam t_state InitHash = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam t_word PadWord  = 32'h80000000;
    localparam t_word LenFirst = 32'd640;
    localparam t_word LenSecond = 32'd256;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // One round: advance the working state; sched_step slides the message window by one word.
    function automatic t_state round_step(input t_state v, input t_word k, input t_word w);
        t_word s1, ch, s0, mj, t1, t2;
        t_state r;
        s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1 = v[7] + s1 + ch + k + w;
        t2 = s0 + mj;
        r[7] = v[6];
        r[6] = v[5];
        r[5] = v[4];
        r[4] = v[3] + t1;
        r[3] = v[2];
        r[2] = v[1];
        r[1] = v[0];
        r[0] = t1 + t2;
        round_step = r;
    endfunction

    function automatic t_window sched_step(input t_window w);
        t_word s0, s1;
        t_window r;
        s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
        s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
        for (int i = 0; i < 15; i++) begin
            r[i] = w[i + 1];
        end
        r[15] = s1 + w[9] + s0 + w[0];
        sched_step = r;
    endfunction

endpackage

// ----- rtl/double_sha256_header_hasher_top.sv -----
// Top level of the fully unrolled double SHA-256 header hasher.
//
// Usage: write the midstate (registers 0..3) and the header tail (registers 4 and 5)
// through the configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
// while no nonce is in flight; o_cfg_ready is always high and unknown indexes are ignored.
// A nonce is taken on i_nonce at every clock edge where i_start is high and o_busy is
// low; o_busy is always low, so one nonce can be taken in every cycle.
// Each of the two compressions is unrolled into 64 round stages plus one stage for the
// final state addition, so each round adder chain sits between two registers. The
// digest is on the o_digest_* ports for one cycle with o_done high, together with
// o_nonce_echo, once the nonce has passed through all stages.
// Throughput is one digest per cycle.
// The receiver cannot stall the result; every pipeline stage simply advances each cycle.
// Synchronous reset clears the configuration registers and all stage valid bits; the
// data registers are not reset.
module double_sha256_header_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_nonce,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_done,
    output logic [63:0] o_digest_words_0_1,
    output logic [63:0] o_digest_words_2_3,
    output logic [63:0] o_digest_words_4_5,
    output logic [63:0] o_digest_words_6_7,
    output logic [31:0] o_nonce_echo
);

    localparam int unsigned Depth = 2 * (dsha_pkg::NumRounds + 1);

    dsha_pkg::t_state  r_mid;
    dsha_pkg::t_word   r_tail0, r_tail1, r_tail2;

    // Per-stage registers: working state, message window, chaining state, nonce.
    dsha_pkg::t_state  r_v   [Depth];
    dsha_pkg::t_window r_w   [Depth];
    dsha_pkg::t_state  r_h   [Depth];
    dsha_pkg::t_word   r_n   [Depth];
    logic [Depth-1:0]  r_vld;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= '0;
            r_tail0 <= '0;
            r_tail1 <= '0;
            r_tail2 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dsha_pkg::REG_MID_01:  {r_mid[0], r_mid[1]} <= i_cfg_data;
                dsha_pkg::REG_MID_23:  {r_mid[2], r_mid[3]} <= i_cfg_data;
                dsha_pkg::REG_MID_45:  {r_mid[4], r_mid[5]} <= i_cfg_data;
                dsha_pkg::REG_MID_67:  {r_mid[6], r_mid[7]} <= i_cfg_data;
                dsha_pkg::REG_TAIL_01: {r_tail0, r_tail1}   <= i_cfg_data;
                dsha_pkg::REG_TAIL_2:  r_tail2              <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Depth-2:0], i_start};
        end
    end

    dsha_pkg::t_window n_w0;
    always_comb begin
        n_w0     = '0;
        n_w0[0]  = r_tail0;
        n_w0[1]  = r_tail1;
        n_w0[2]  = r_tail2;
        n_w0[3]  = {i_nonce[7:0], i_nonce[15:8], i_nonce[23:16], i_nonce[31:24]};
        n_w0[4]  = dsha_pkg::PadWord;
        n_w0[15] = dsha_pkg::LenFirst;
    end

    always_ff @(posedge i_clk) begin
        r_v[0] <= dsha_pkg::round_step(r_mid, dsha_pkg::RoundK[0], n_w0[0]);
        r_w[0] <= dsha_pkg::sched_step(n_w0);
        r_h[0] <= r_mid;
        r_n[0] <= i_nonce;
    end

    for (genvar s = 1; s < Depth; s++) begin : g_stage
        localparam int unsigned Pos = s % (dsha_pkg::NumRounds + 1);
        if (Pos == dsha_pkg::NumRounds) begin : g_fin
            // Final addition; for the first hash also set up the second block.
            dsha_pkg::t_state  n_sum;
            dsha_pkg::t_window n_msg;
            always_comb begin
                for (int i = 0; i < 8; i++) begin
                    n_sum[i] = r_h[s-1][i] + r_v[s-1][i];
                end
                n_msg     = '0;
                for (int i = 0; i < 8; i++) begin
                    n_msg[i] = n_sum[i];
                end
                n_msg[8]  = dsha_pkg::PadWord;
                n_msg[15] = dsha_pkg::LenSecond;
            end
            always_ff @(posedge i_clk) begin
                r_v[s] <= (s < Depth - 1) ? dsha_pkg::InitHash : n_sum;
                r_w[s] <= n_msg;
                r_h[s] <= dsha_pkg::InitHash;
                r_n[s] <= r_n[s-1];
            end
        end else begin : g_rnd
            always_ff @(posedge i_clk) begin
                r_v[s] <= dsha_pkg::round_step(r_v[s-1], dsha_pkg::RoundK[Pos], r_w[s-1][0]);
                r_w[s] <= dsha_pkg::sched_step(r_w[s-1]);
                r_h[s] <= r_h[s-1];
                r_n[s] <= r_n[s-1];
            end
        end
    end

    assign o_done             = r_vld[Depth-1];
    assign o_digest_words_0_1 = {r_v[Depth-1][0], r_v[Depth-1][1]};
    assign o_digest_words_2_3 = {r_v[Depth-1][2], r_v[Depth-1][3]};
    assign o_digest_words_4_5 = {r_v[Depth-1][4], r_v[Depth-1][5]};
    assign o_digest_words_6_7 = {r_v[Depth-1][6], r_v[Depth-1][7]};
    assign o_nonce_echo       = r_n[Depth-1];

endmodule

// ----- dv/dsha_checker.sv -----
// Checker for the double SHA-256 header hasher: tracks configuration, predicts and compares digests.
module dsha_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_nonce,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_done,
    input  logic [63:0] i_digest_words_0_1,
    input  logic [63:0] i_digest_words_2_3,
    input  logic [63:0] i_digest_words_4_5,
    input  logic [63:0] i_digest_words_6_7,
    input  logic [31:0] i_nonce_echo,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] d01;
        logic [63:0] d23;
        logic [63:0] d45;
        logic [63:0] d67;
        logic [31:0] nonce;
    } t_digest_rec;

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [63:0]  hdr_regs [dsha_pkg::NumRegs];
    t_digest_rec  digest_fifo [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Compresses one 16-word block into the chaining value h.
    function automatic void sha_block(inout logic [31:0] h [8], input logic [31:0] m [16]);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = m[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        {a, b, c, d, e, f, g, hh} = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    endfunction

    function automatic t_digest_rec hash_header(input logic [31:0] nonce);
        logic [31:0] h [8];
        logic [31:0] m [16];
        t_digest_rec r;
        for (int i = 0; i < 4; i++) begin
            h[2*i]   = hdr_regs[i][63:32];
            h[2*i+1] = hdr_regs[i][31:0];
        end
        foreach (m[i]) m[i] = '0;
        m[0]  = hdr_regs[dsha_pkg::REG_TAIL_01][63:32];
        m[1]  = hdr_regs[dsha_pkg::REG_TAIL_01][31:0];
        m[2]  = hdr_regs[dsha_pkg::REG_TAIL_2][31:0];
        m[3]  = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
        m[4]  = 32'h80000000;
        m[15] = 32'd640;
        sha_block(h, m);
        foreach (m[i]) m[i] = '0;
        for (int i = 0; i < 8; i++) m[i] = h[i];
        m[8]  = 32'h80000000;
        m[15] = 32'd256;
        h = IV;
        sha_block(h, m);
        r.d01 = {h[0], h[1]};
        r.d23 = {h[2], h[3]};
        r.d45 = {h[4], h[5]};
        r.d67 = {h[6], h[7]};
        r.nonce = nonce;
        return r;
    endfunction

    function automatic void cmp64(input string fname, input logic [63:0] exp_v,
                                  input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_digest_rec exp_r;
        if (!i_rst_n) begin
            foreach (hdr_regs[i]) hdr_regs[i] <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < dsha_pkg::NumRegs) begin
                // The last tail register holds a single word; its upper half is dropped.
                if (i_cfg_index == dsha_pkg::REG_TAIL_2) begin
                    hdr_regs[i_cfg_index] <= {32'd0, i_cfg_data[31:0]};
                end else begin
                    hdr_regs[i_cfg_index] <= i_cfg_data;
                end
            end
            if (i_start && !i_busy) digest_fifo.push_back(hash_header(i_nonce));
            if (i_done) begin
                if (digest_fifo.size() == 0) begin
                    $display("%0t: unexpected digest, expected none, actual nonce %h",
                             $time, i_nonce_echo);
                    o_fail_count++;
                end else begin
                    exp_r = digest_fifo.pop_front();
                    cmp64("digest_words_0_1", exp_r.d01, i_digest_words_0_1);
                    cmp64("digest_words_2_3", exp_r.d23, i_digest_words_2_3);
                    cmp64("digest_words_4_5", exp_r.d45, i_digest_words_4_5);
                    cmp64("digest_words_6_7", exp_r.d67, i_digest_words_6_7);
                    cmp64("nonce_echo", {32'd0, exp_r.nonce}, {32'd0, i_nonce_echo});
                end
            end
        end
        o_pending = digest_fifo.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the double SHA-256 header hasher: stimulus, watchdog and verdict.
module tb;

    localparam int          DrainCycles   = 140;
    localparam int          WatchdogLimit = 2000;
    localparam logic [2:0]  CfgIdxSpareLo = 3'd6;
    localparam logic [2:0]  CfgIdxSpareHi = 3'd7;

    logic        i_clk, i_rst_n, i_start, i_cfg_valid;
    logic [31:0] i_nonce;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        o_busy, o_cfg_ready, o_done;
    logic [63:0] o_digest_words_0_1, o_digest_words_2_3, o_digest_words_4_5, o_digest_words_6_7;
    logic [31:0] o_nonce_echo;
    int          fail_count, pending;
    int          quiet_cycles = 0;
    bit          gaps_on;

    double_sha256_header_hasher_top DUT (.*);

    dsha_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_nonce,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_done(o_done), .i_digest_words_0_1(o_digest_words_0_1),
        .i_digest_words_2_3(o_digest_words_2_3), .i_digest_words_4_5(o_digest_words_4_5),
        .i_digest_words_6_7(o_digest_words_6_7), .i_nonce_echo(o_nonce_echo),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("** double_sha256_header_hasher_top: FAILED **");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_nonce(input logic [31:0] n);
        bit ok;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_nonce <= n;
        do begin
            @(negedge i_clk);
            ok = !o_busy;
            @(posedge i_clk);
        end while (!ok);
    endtask

    // Lowers start and waits until every digest in flight has come out.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
    endtask

    // style 0: all zeros, 1: all ones, otherwise random contents.
    task automatic program_header(input int style);
        logic [63:0] v;
        for (int r = 0; r < dsha_pkg::NumRegs; r++) begin
            v = (style == 0) ? 64'd0 : (style == 1) ? '1 : rand64();
            write_reg(dsha_pkg::t_reg_idx'(r), v);
        end
        write_reg(CfgIdxSpareLo, rand64());
        write_reg(CfgIdxSpareHi, rand64());
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_nonces(input int count);
        for (int i = 0; i < count; i++) push_nonce($urandom);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_nonce     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        gaps_on = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unconfigured midstate: everything still zero after reset.
        push_nonce(32'h0000_0000);
        push_nonce(32'hffff_ffff);
        push_nonce(32'h0102_0304);
        drain();
        program_header(1);
        push_nonce(32'h0000_0000);
        push_nonce(32'hffff_ffff);
        push_nonce(32'h8000_0001);
        for (int b = 0; b < 32; b += 4) push_nonce(32'd1 << b);
        drain();
        program_header(0);
        push_nonce(32'hffff_ffff);
        push_nonce(32'h5a5a_a5a5);
        drain();
        // Tail word written with its upper half set; only the low word may count.
        program_header(2);
        write_reg(dsha_pkg::REG_TAIL_2, {32'hdead_beef, $urandom});
        i_cfg_valid <= 1'b0;
        push_nonce(32'h0000_0000);
        push_nonce(32'hffff_ffff);
        push_nonce($urandom);
        drain();

        gaps_on = 1'b1;
        for (int ph = 0; ph < 5; ph++) begin
            program_header((ph == 1) ? 1 : (ph == 3) ? 0 : 2);
            random_nonces(100);
            // Hold off the sender until the pipeline has emptied.
            if (ph == 2) begin
                drain();
                gaps_on = 1'b1;
            end
            random_nonces(100);
            drain();
        end
        // Final stretch runs back to back.
        gaps_on = 1'b0;
        program_header(2);
        random_nonces(200);
        drain();
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("** double_sha256_header_hasher_top: PASSED **");
        end else begin
            $display("** double_sha256_header_hasher_top: FAILED **");
        end
        $finish;
    end

endmodule
